/* rtl/core/bracket_match_checker_unit_assert.svh */
// assertion macros for the bracket match checker
// used by rtl/core modules that carry concurrent checks
`ifndef BRACKET_MATCH_CHECKER_UNIT_ASSERT_SVH
`define BRACKET_MATCH_CHECKER_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define BMCU_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define BMCU_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/bmc_pkg.sv */
// bmc_pkg: types, constants and bracket decode for the bracket match checker
// no dependencies
`timescale 1ns / 1ps

package bmc_pkg;

   localparam int STACK_DEPTH_DEFAULT = 256;

   localparam int SYM_W   = 8;
   localparam int SCORE_W = 16;
   localparam int DEPTH_W = 9;
   localparam int TOTAL_W = 32;
   localparam int CSR_IDX_W = 8;
   localparam int NUM_SCORES = 4;

   typedef logic [1:0] kind_type;

   localparam kind_type KIND_ROUND  = 2'd0;
   localparam kind_type KIND_SQUARE = 2'd1;
   localparam kind_type KIND_CURLY  = 2'd2;
   localparam kind_type KIND_ANGLE  = 2'd3;

   localparam logic [SYM_W-1:0] CH_OPEN_ROUND   = 8'h28;
   localparam logic [SYM_W-1:0] CH_CLOSE_ROUND  = 8'h29;
   localparam logic [SYM_W-1:0] CH_OPEN_SQUARE  = 8'h5b;
   localparam logic [SYM_W-1:0] CH_CLOSE_SQUARE = 8'h5d;
   localparam logic [SYM_W-1:0] CH_OPEN_CURLY   = 8'h7b;
   localparam logic [SYM_W-1:0] CH_CLOSE_CURLY  = 8'h7d;
   localparam logic [SYM_W-1:0] CH_OPEN_ANGLE   = 8'h3c;
   localparam logic [SYM_W-1:0] CH_CLOSE_ANGLE  = 8'h3e;
   localparam logic [SYM_W-1:0] CH_NONE         = 8'h00;

   localparam logic [CSR_IDX_W-1:0] CSR_SCORE_ROUND  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCORE_SQUARE = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCORE_CURLY  = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SCORE_ANGLE  = 8'd3;

   localparam logic [SCORE_W-1:0] SCORE_ROUND_RESET  = 16'd3;
   localparam logic [SCORE_W-1:0] SCORE_SQUARE_RESET = 16'd57;
   localparam logic [SCORE_W-1:0] SCORE_CURLY_RESET  = 16'd1197;
   localparam logic [SCORE_W-1:0] SCORE_ANGLE_RESET  = 16'd25137;

   typedef enum logic [1:0] {
      STK_HOLD,
      STK_PUSH,
      STK_POP
   } stk_op_type;

   typedef struct packed {
      stk_op_type op;
      logic       clear;
      kind_type   kind;
   } stk_cmd_type;

   typedef struct packed {
      logic                 empty;
      logic                 full;
      logic                 deep;
      kind_type             top;
      logic [DEPTH_W-1:0]   depth;
   } stk_status_type;

   typedef struct packed {
      logic [SYM_W-1:0] symbol;
      logic             line_end;
   } req_type;

   typedef struct packed {
      logic [SCORE_W-1:0] line_score;
      logic               corrupted;
      logic [SYM_W-1:0]   expected_closer;
      logic [SYM_W-1:0]   found_closer;
      logic               underflow;
      logic               overflow;
      logic [DEPTH_W-1:0] open_depth;
      logic [TOTAL_W-1:0] total_score;
   } rsp_type;

   typedef struct packed {
      logic     is_open;
      logic     is_close;
      kind_type kind;
   } sym_class_type;

   function automatic sym_class_type classify(input logic [SYM_W-1:0] sym);
      sym_class_type c;
      c = '{is_open: 1'b0, is_close: 1'b0, kind: KIND_ROUND};
      case (sym)
         CH_OPEN_ROUND:   c = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_ROUND};
         CH_OPEN_SQUARE:  c = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_SQUARE};
         CH_OPEN_CURLY:   c = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_CURLY};
         CH_OPEN_ANGLE:   c = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_ANGLE};
         CH_CLOSE_ROUND:  c = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_ROUND};
         CH_CLOSE_SQUARE: c = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_SQUARE};
         CH_CLOSE_CURLY:  c = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_CURLY};
         CH_CLOSE_ANGLE:  c = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_ANGLE};
         default:         c = '{is_open: 1'b0, is_close: 1'b0, kind: KIND_ROUND};
      endcase
      return c;
   endfunction

   function automatic logic [SYM_W-1:0] closer_char(input kind_type k);
      logic [SYM_W-1:0] ch;
      case (k)
         KIND_ROUND:  ch = CH_CLOSE_ROUND;
         KIND_SQUARE: ch = CH_CLOSE_SQUARE;
         KIND_CURLY:  ch = CH_CLOSE_CURLY;
         default:     ch = CH_CLOSE_ANGLE;
      endcase
      return ch;
   endfunction

endpackage

/* rtl/core/bracket_match_checker_unit.sv */
// latency: a result word appears the cycle after its line-end word is accepted
// throughput: one word per cycle; the stack top sits in the first cell register
// and each word does at most one shift of the cell row, so the next word sees it at once
// a word is stalled only when it ends a line and the previous result is not taken
// reset: synchronous, clears stack count, line state and total; scores to defaults
// bracket_match_checker_unit: top level; depends on bmc_pkg, bmc_stack, macro header
`timescale 1ns / 1ps

module bracket_match_checker_unit
   import bmc_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_word,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_word,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SCORE_W-1:0]   csr_wdata
);

`include "bracket_match_checker_unit_assert.svh"

   logic [SCORE_W-1:0] score_ff [NUM_SCORES];

   logic               failed_ff,    failed_in;
   logic [SCORE_W-1:0] err_score_ff, err_score_in;
   logic [SYM_W-1:0]   err_exp_ff,   err_exp_in;
   logic [SYM_W-1:0]   err_found_ff, err_found_in;
   logic               err_under_ff, err_under_in;
   logic               ovf_ff,       ovf_in;
   logic [TOTAL_W-1:0] total_ff,     total_in;
   rsp_type            rsp_ff,       rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               accept;
   logic               line_done;
   logic [TOTAL_W:0]   sum;
   sym_class_type      cls;
   stk_cmd_type        cmd;
   stk_status_type     status;

   bmc_stack #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .status (status)
   );

   assign req_ready = !rsp_valid_ff || rsp_ready || !req_word.line_end;
   assign accept    = req_valid && req_ready;
   assign line_done = accept && req_word.line_end;
   assign cls       = classify(req_word.symbol);

   always_comb begin
      cmd.op       = STK_HOLD;
      cmd.kind     = cls.kind;
      cmd.clear    = line_done;
      failed_in    = failed_ff;
      err_score_in = err_score_ff;
      err_exp_in   = err_exp_ff;
      err_found_in = err_found_ff;
      err_under_in = err_under_ff;
      ovf_in       = ovf_ff;

      if (accept && !failed_ff) begin
         if (cls.is_open) begin
            if (status.full) begin
               ovf_in = 1'b1;
            end else begin
               cmd.op = STK_PUSH;
            end
         end else if (cls.is_close) begin
            if (status.empty) begin
               failed_in    = 1'b1;
               err_under_in = 1'b1;
               err_exp_in   = CH_NONE;
               err_found_in = req_word.symbol;
               err_score_in = score_ff[cls.kind];
            end else begin
               cmd.op = STK_POP;
               if (status.top != cls.kind) begin
                  failed_in    = 1'b1;
                  err_under_in = 1'b0;
                  err_exp_in   = closer_char(status.top);
                  err_found_in = req_word.symbol;
                  err_score_in = score_ff[cls.kind];
               end
            end
         end
      end

      sum      = {1'b0, total_ff} + (TOTAL_W + 1)'(err_score_in);
      total_in = total_ff;
      if (line_done) begin
         total_in = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
      end

      rsp_in.line_score      = err_score_in;
      rsp_in.corrupted       = failed_in;
      rsp_in.expected_closer = err_exp_in;
      rsp_in.found_closer    = err_found_in;
      rsp_in.underflow       = err_under_in;
      rsp_in.overflow        = ovf_in;
      rsp_in.open_depth      = status.depth;
      if (cmd.op == STK_PUSH && status.depth != '1) begin
         rsp_in.open_depth = status.depth + DEPTH_W'(1);
      end else if (cmd.op == STK_POP) begin
         rsp_in.open_depth = status.deep ? '1 : status.depth - DEPTH_W'(1);
      end
      rsp_in.total_score     = total_in;

      if (line_done) begin
         failed_in    = 1'b0;
         err_score_in = '0;
         err_exp_in   = CH_NONE;
         err_found_in = CH_NONE;
         err_under_in = 1'b0;
         ovf_in       = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (line_done) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         failed_ff    <= 1'b0;
         err_score_ff <= '0;
         err_exp_ff   <= CH_NONE;
         err_found_ff <= CH_NONE;
         err_under_ff <= 1'b0;
         ovf_ff       <= 1'b0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         failed_ff    <= failed_in;
         err_score_ff <= err_score_in;
         err_exp_ff   <= err_exp_in;
         err_found_ff <= err_found_in;
         err_under_ff <= err_under_in;
         ovf_ff       <= ovf_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (line_done) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         score_ff[KIND_ROUND]  <= SCORE_ROUND_RESET;
         score_ff[KIND_SQUARE] <= SCORE_SQUARE_RESET;
         score_ff[KIND_CURLY]  <= SCORE_CURLY_RESET;
         score_ff[KIND_ANGLE]  <= SCORE_ANGLE_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_SCORE_ROUND:  score_ff[KIND_ROUND]  <= csr_wdata;
            CSR_SCORE_SQUARE: score_ff[KIND_SQUARE] <= csr_wdata;
            CSR_SCORE_CURLY:  score_ff[KIND_CURLY]  <= csr_wdata;
            CSR_SCORE_ANGLE:  score_ff[KIND_ANGLE]  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   `BMCU_ASSERT_NEXT(a_line_end_gives_word, line_done, rsp_valid_ff,
      "line end accepted without a result word")
   `BMCU_ASSERT_NEXT(a_line_state_cleared, line_done, !failed_ff && !ovf_ff,
      "line state not cleared after line end")
   `BMCU_ASSERT_NEXT(a_total_monotonic, accept, total_ff >= $past(total_ff),
      "running total decreased")
   `BMCU_ASSERT_NOW(a_clean_line_no_score, !failed_ff, err_score_ff == '0,
      "score held on a line without error")

endmodule

/* rtl/core/bmc_cell.sv */
// bmc_cell: one entry of the shifting closer stack
// depends on bmc_pkg
`timescale 1ns / 1ps

module bmc_cell
   import bmc_pkg::*;
(
   input  logic       clock,
   input  stk_op_type op,
   input  kind_type   above,
   input  kind_type   below,
   output kind_type   entry
);

   kind_type entry_ff;
   kind_type entry_in;

   always_comb begin
      case (op)
         STK_PUSH: entry_in = above;
         STK_POP:  entry_in = below;
         default:  entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

/* rtl/core/bmc_stack.sv */
// bmc_stack: row of bmc_cell entries shifting on push and pop, plus fill count
// depends on bmc_pkg, bmc_cell and the assertion macro header
`timescale 1ns / 1ps

module bmc_stack
   import bmc_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT
) (
   input  logic           clock,
   input  logic           reset,
   input  stk_cmd_type    cmd,
   output stk_status_type status
);

`include "bracket_match_checker_unit_assert.svh"

   localparam int CNT_W = $clog2(STACK_DEPTH + 1);
   localparam int EXT_W = (CNT_W > DEPTH_W) ? CNT_W : DEPTH_W;
   localparam logic [EXT_W-1:0] DEPTH_SAT = EXT_W'((1 << DEPTH_W) - 1);

   kind_type entries [STACK_DEPTH];

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [EXT_W-1:0] count_ext;

   genvar gi;
   generate
      for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
         kind_type above_w;
         kind_type below_w;
         if (gi == 0) begin : g_top
            assign above_w = cmd.kind;
         end else begin : g_mid
            assign above_w = entries[gi-1];
         end
         if (gi == STACK_DEPTH - 1) begin : g_bot
            assign below_w = KIND_ROUND;
         end else begin : g_up
            assign below_w = entries[gi+1];
         end
         bmc_cell u_cell (
            .clock (clock),
            .op    (cmd.op),
            .above (above_w),
            .below (below_w),
            .entry (entries[gi])
         );
      end
   endgenerate

   always_comb begin
      if (cmd.clear) begin
         count_in = '0;
      end else begin
         case (cmd.op)
            STK_PUSH: count_in = count_ff + CNT_W'(1);
            STK_POP:  count_in = count_ff - CNT_W'(1);
            default:  count_in = count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign count_ext    = EXT_W'(count_ff);
   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CNT_W'(STACK_DEPTH));
   assign status.deep  = (count_ext > DEPTH_SAT);
   assign status.top   = entries[0];
   assign status.depth = (count_ext > DEPTH_SAT) ? DEPTH_SAT[DEPTH_W-1:0]
                                                 : count_ext[DEPTH_W-1:0];

   `BMCU_ASSERT_NOW(a_no_push_when_full, status.full, cmd.op != STK_PUSH,
      "push issued on a full stack")
   `BMCU_ASSERT_NOW(a_no_pop_when_empty, status.empty, cmd.op != STK_POP,
      "pop issued on an empty stack")
   `BMCU_ASSERT_NEXT(a_clear_empties, cmd.clear, status.empty,
      "stack not empty after line clear")

endmodule

/* tb/bracket_match_checker_unit_tb.sv */
// self-checking testbench for bracket_match_checker_unit: directed lines, then random lines
// checked against an in-bench score and stack tracker; depends on bmc_pkg and the unit rtl
`timescale 1ns / 1ps

module bracket_match_checker_unit_tb;
   import bmc_pkg::*;

   localparam int DEPTH = STACK_DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int HOLD_CYCLES = 400;
   localparam logic [4*SYM_W-1:0] OPEN_SET =
      {CH_OPEN_ANGLE, CH_OPEN_CURLY, CH_OPEN_SQUARE, CH_OPEN_ROUND};
   localparam logic [4*SYM_W-1:0] CLOSE_SET =
      {CH_CLOSE_ANGLE, CH_CLOSE_CURLY, CH_CLOSE_SQUARE, CH_CLOSE_ROUND};

   typedef struct {
      req_type word;
      bit      typed;
      rsp_type want;
   } stim_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_word = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_word;
   logic                 csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [SCORE_W-1:0]   csr_wdata = '0;

   // tracker state
   kind_type           stack_mem [DEPTH];
   int                 stack_fill = 0;
   bit                 line_bad = 1'b0;
   logic [SCORE_W-1:0] err_score = '0;
   logic [SYM_W-1:0]   err_expected = '0;
   logic [SYM_W-1:0]   err_found = '0;
   bit                 err_underflow = 1'b0;
   bit                 overflow_seen = 1'b0;
   logic [TOTAL_W-1:0] running_total = '0;
   logic [SCORE_W-1:0] score_tab [NUM_SCORES];

   rsp_type      expected_lines [$];
   stim_row_type directed_rows [$];
   rsp_type      monitor_want;
   int           mismatch_count = 0;
   int           words_sent = 0;
   int           sender_idle_pct = 0;
   int           reader_idle_pct = 0;
   bit           hold_toggle = 1'b0;
   bit           hold_seen = 1'b0;
   int           hold_left = 0;

   bracket_match_checker_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // one word through the stack tracker; returns 1 with the line result on a line end
   function automatic bit bracket_step(input req_type w, output rsp_type r);
      bit                 is_open;
      bit                 is_close;
      kind_type           kind;
      kind_type           top;
      logic [SCORE_W-1:0] score;
      is_open = 1'b0;
      is_close = 1'b0;
      kind = KIND_ROUND;
      r = '0;
      for (int k = 0; k < NUM_SCORES; k++) begin
         if (w.symbol == OPEN_SET[k*SYM_W +: SYM_W]) begin
            is_open = 1'b1;
            kind = kind_type'(k);
         end
         if (w.symbol == CLOSE_SET[k*SYM_W +: SYM_W]) begin
            is_close = 1'b1;
            kind = kind_type'(k);
         end
      end
      if (!line_bad) begin
         if (is_open) begin
            if (stack_fill < DEPTH) begin
               stack_mem[stack_fill] = kind;
               stack_fill++;
            end else begin
               overflow_seen = 1'b1;
            end
         end else if (is_close) begin
            if (stack_fill == 0) begin
               line_bad = 1'b1;
               err_underflow = 1'b1;
               err_expected = CH_NONE;
               err_found = w.symbol;
               err_score = score_tab[kind];
            end else begin
               stack_fill--;
               top = stack_mem[stack_fill];
               if (top != kind) begin
                  line_bad = 1'b1;
                  err_underflow = 1'b0;
                  err_expected = CLOSE_SET[top*SYM_W +: SYM_W];
                  err_found = w.symbol;
                  err_score = score_tab[kind];
               end
            end
         end
      end
      if (!w.line_end) return 1'b0;
      score = line_bad ? err_score : '0;
      if (running_total > 32'hFFFF_FFFF - score) running_total = 32'hFFFF_FFFF;
      else running_total = running_total + score;
      r.line_score = score;
      r.corrupted = line_bad;
      r.expected_closer = line_bad ? err_expected : CH_NONE;
      r.found_closer = line_bad ? err_found : CH_NONE;
      r.underflow = line_bad && err_underflow;
      r.overflow = overflow_seen;
      r.open_depth = (stack_fill > 511) ? 9'd511 : DEPTH_W'(stack_fill);
      r.total_score = running_total;
      stack_fill = 0;
      line_bad = 1'b0;
      err_score = '0;
      err_expected = CH_NONE;
      err_found = CH_NONE;
      err_underflow = 1'b0;
      overflow_seen = 1'b0;
      return 1'b1;
   endfunction

   function automatic rsp_type mk_rsp(input logic [SCORE_W-1:0] score, input logic corrupted,
                                      input logic [SYM_W-1:0] exp_ch,
                                      input logic [SYM_W-1:0] found_ch, input logic under,
                                      input logic over, input logic [DEPTH_W-1:0] depth,
                                      input logic [TOTAL_W-1:0] total);
      rsp_type r;
      r.line_score = score;
      r.corrupted = corrupted;
      r.expected_closer = exp_ch;
      r.found_closer = found_ch;
      r.underflow = under;
      r.overflow = over;
      r.open_depth = depth;
      r.total_score = total;
      return r;
   endfunction

   function automatic void add_row(input logic [SYM_W-1:0] sym, input bit last, input bit typed,
                                   input rsp_type want);
      stim_row_type row;
      row.word.symbol = sym;
      row.word.line_end = last;
      row.typed = typed;
      row.want = want;
      directed_rows.push_back(row);
   endfunction

   function automatic string rsp_text(input rsp_type r);
      return $sformatf({"score=%0d corrupted=%0b exp=%h found=%h ",
                        "under=%0b over=%0b depth=%0d total=%0d"},
                       r.line_score, r.corrupted, r.expected_closer, r.found_closer,
                       r.underflow, r.overflow, r.open_depth, r.total_score);
   endfunction

   task automatic report_mismatch(input string what, input rsp_type want, input rsp_type got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%0t mismatch: %s", $realtime, what);
         $display("   expected %s", rsp_text(want));
         $display("   actual   %s", rsp_text(got));
      end
   endtask

   task automatic send_word(input req_type w, input bit typed, input rsp_type want);
      rsp_type r;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (!req_ready);
      words_sent++;
      if (bracket_step(w, r)) expected_lines.push_back(typed ? want : r);
   endtask

   // drop valid, drain all line results, then let the pipeline go quiet
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_lines.size() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_score(input logic [CSR_IDX_W-1:0] idx, input logic [SCORE_W-1:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_SCORE_ROUND:  score_tab[KIND_ROUND] = val;
         CSR_SCORE_SQUARE: score_tab[KIND_SQUARE] = val;
         CSR_SCORE_CURLY:  score_tab[KIND_CURLY] = val;
         CSR_SCORE_ANGLE:  score_tab[KIND_ANGLE] = val;
         default: ;
      endcase
   endtask

   task automatic program_scores(input logic [SCORE_W-1:0] round_val,
                                 input logic [SCORE_W-1:0] square_val,
                                 input logic [SCORE_W-1:0] curly_val,
                                 input logic [SCORE_W-1:0] angle_val,
                                 input logic [CSR_IDX_W-1:0] junk_index);
      write_score(CSR_SCORE_ROUND, round_val);
      write_score(CSR_SCORE_SQUARE, square_val);
      write_score(CSR_SCORE_CURLY, curly_val);
      write_score(CSR_SCORE_ANGLE, angle_val);
      write_score(junk_index, SCORE_W'($urandom));
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_random_line();
      logic [SYM_W-1:0] syms [$];
      kind_type         open_k [$];
      kind_type         k;
      req_type          w;
      int               mode;
      int               n;
      int               closes;
      mode = $urandom_range(99);
      n = $urandom_range(1, 20);
      if (mode < 55) begin
         // well-formed body with a little noise
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) == 0) begin
               syms.push_back(SYM_W'($urandom_range(255)));
            end else if (open_k.size() > 0 && $urandom_range(1) == 1) begin
               k = open_k.pop_back();
               syms.push_back(CLOSE_SET[k*SYM_W +: SYM_W]);
            end else begin
               k = kind_type'($urandom_range(3));
               open_k.push_back(k);
               syms.push_back(OPEN_SET[k*SYM_W +: SYM_W]);
            end
         end
         if (mode < 35) begin
            while (open_k.size() > 0) begin
               k = open_k.pop_back();
               syms.push_back(CLOSE_SET[k*SYM_W +: SYM_W]);
            end
         end else if (mode < 50) begin
            // wrong closer, or a closer on an empty stack
            k = kind_type'($urandom_range(3));
            if (open_k.size() > 0 && k == open_k[$]) k = k + 2'd1;
            syms.push_back(CLOSE_SET[k*SYM_W +: SYM_W]);
            repeat ($urandom_range(0, 6)) begin
               k = kind_type'($urandom_range(3));
               syms.push_back($urandom_range(1) ? OPEN_SET[k*SYM_W +: SYM_W]
                                                : CLOSE_SET[k*SYM_W +: SYM_W]);
            end
         end
      end else if (mode < 75) begin
         repeat (n) syms.push_back(SYM_W'($urandom_range(255)));
      end else if (mode < 80) begin
         repeat (n) begin
            k = kind_type'($urandom_range(3));
            syms.push_back($urandom_range(1) ? OPEN_SET[k*SYM_W +: SYM_W]
                                             : CLOSE_SET[k*SYM_W +: SYM_W]);
         end
      end else begin
         // deep nesting, near full now and then
         n = (mode < 99) ? $urandom_range(20, 100) : $urandom_range(DEPTH - 2, DEPTH + 3);
         repeat (n) begin
            k = kind_type'($urandom_range(3));
            open_k.push_back(k);
            syms.push_back(OPEN_SET[k*SYM_W +: SYM_W]);
         end
         closes = $urandom_range(0, n);
         while (closes > 0 && open_k.size() > 0) begin
            k = open_k.pop_back();
            syms.push_back(CLOSE_SET[k*SYM_W +: SYM_W]);
            closes--;
         end
         if ($urandom_range(3) == 0) begin
            k = kind_type'($urandom_range(3));
            syms.push_back(CLOSE_SET[k*SYM_W +: SYM_W]);
         end
      end
      if (syms.size() == 0) syms.push_back(SYM_W'($urandom_range(255)));
      foreach (syms[i]) begin
         w.symbol = syms[i];
         w.line_end = (i == syms.size() - 1);
         send_word(w, 1'b0, '0);
      end
   endtask

   task automatic run_lines(input int word_budget);
      int target;
      target = words_sent + word_budget;
      while (words_sent < target) send_random_line();
   endtask

   // result side: random stalls, plus one long hold-off on request
   always @(posedge clock) begin
      if (hold_toggle != hold_seen) begin
         hold_seen <= hold_toggle;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= reader_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_lines.size() == 0) begin
            report_mismatch("result with no line pending", '0, rsp_word);
         end else begin
            monitor_want = expected_lines.pop_front();
            if (rsp_word.line_score !== monitor_want.line_score
                  || rsp_word.corrupted !== monitor_want.corrupted
                  || rsp_word.expected_closer !== monitor_want.expected_closer
                  || rsp_word.found_closer !== monitor_want.found_closer
                  || rsp_word.underflow !== monitor_want.underflow
                  || rsp_word.overflow !== monitor_want.overflow
                  || rsp_word.open_depth !== monitor_want.open_depth
                  || rsp_word.total_score !== monitor_want.total_score)
               report_mismatch("line result differs", monitor_want, rsp_word);
         end
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("bracket_match_checker_unit_tb NOT OK");
      $finish;
   end

   initial begin
      req_type w;
      score_tab[KIND_ROUND] = SCORE_ROUND_RESET;
      score_tab[KIND_SQUARE] = SCORE_SQUARE_RESET;
      score_tab[KIND_CURLY] = SCORE_CURLY_RESET;
      score_tab[KIND_ANGLE] = SCORE_ANGLE_RESET;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // closer on empty stack
      add_row(CH_CLOSE_ROUND, 1'b1, 1'b1,
              mk_rsp(SCORE_ROUND_RESET, 1'b1, CH_NONE, CH_CLOSE_ROUND,
                     1'b1, 1'b0, 9'd0, 32'd3));
      // mismatches on the square, angle and curly closers
      add_row(CH_OPEN_ROUND, 1'b0, 1'b0, '0);
      add_row(CH_CLOSE_SQUARE, 1'b1, 1'b1,
              mk_rsp(SCORE_SQUARE_RESET, 1'b1, CH_CLOSE_ROUND, CH_CLOSE_SQUARE,
                     1'b0, 1'b0, 9'd0, 32'd60));
      add_row(CH_OPEN_CURLY, 1'b0, 1'b0, '0);
      add_row(CH_CLOSE_ANGLE, 1'b1, 1'b1,
              mk_rsp(SCORE_ANGLE_RESET, 1'b1, CH_CLOSE_CURLY, CH_CLOSE_ANGLE,
                     1'b0, 1'b0, 9'd0, 32'd25197));
      add_row(CH_OPEN_ANGLE, 1'b0, 1'b0, '0);
      add_row(CH_CLOSE_CURLY, 1'b1, 1'b1,
              mk_rsp(SCORE_CURLY_RESET, 1'b1, CH_CLOSE_ANGLE, CH_CLOSE_CURLY,
                     1'b0, 1'b0, 9'd0, 32'd26394));
      // rest of the line ignored after the first error
      add_row(CH_OPEN_SQUARE, 1'b0, 1'b0, '0);
      add_row(CH_CLOSE_ROUND, 1'b0, 1'b0, '0);
      add_row(CH_OPEN_ROUND, 1'b0, 1'b0, '0);
      add_row(CH_OPEN_CURLY, 1'b1, 1'b1,
              mk_rsp(SCORE_ROUND_RESET, 1'b1, CH_CLOSE_SQUARE, CH_CLOSE_ROUND,
                     1'b0, 1'b0, 9'd0, 32'd26397));
      // clean nested line
      add_row(CH_OPEN_ROUND, 1'b0, 1'b0, '0);
      add_row(CH_OPEN_SQUARE, 1'b0, 1'b0, '0);
      add_row(CH_OPEN_CURLY, 1'b0, 1'b0, '0);
      add_row(CH_OPEN_ANGLE, 1'b0, 1'b0, '0);
      add_row(CH_CLOSE_ANGLE, 1'b0, 1'b0, '0);
      add_row(CH_CLOSE_CURLY, 1'b0, 1'b0, '0);
      add_row(CH_CLOSE_SQUARE, 1'b0, 1'b0, '0);
      add_row(CH_CLOSE_ROUND, 1'b1, 1'b1,
              mk_rsp(16'd0, 1'b0, CH_NONE, CH_NONE, 1'b0, 1'b0, 9'd0, 32'd26397));
      // other characters only
      add_row(8'hFF, 1'b0, 1'b0, '0);
      add_row(CH_NONE, 1'b1, 1'b1,
              mk_rsp(16'd0, 1'b0, CH_NONE, CH_NONE, 1'b0, 1'b0, 9'd0, 32'd26397));
      // openers left open
      add_row(CH_OPEN_ROUND, 1'b0, 1'b0, '0);
      add_row(CH_OPEN_ANGLE, 1'b1, 1'b1,
              mk_rsp(16'd0, 1'b0, CH_NONE, CH_NONE, 1'b0, 1'b0, 9'd2, 32'd26397));
      // underflow first, second closer ignored
      add_row(CH_CLOSE_SQUARE, 1'b0, 1'b0, '0);
      add_row(CH_CLOSE_SQUARE, 1'b1, 1'b1,
              mk_rsp(SCORE_SQUARE_RESET, 1'b1, CH_NONE, CH_CLOSE_SQUARE,
                     1'b1, 1'b0, 9'd0, 32'd26454));
      foreach (directed_rows[i])
         send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);

      // stack exactly full, then pushed past full and closed wrongly
      for (int i = 0; i < DEPTH; i++) begin
         w.symbol = CH_OPEN_SQUARE;
         w.line_end = (i == DEPTH - 1);
         send_word(w, 1'b0, '0);
      end
      for (int i = 0; i < DEPTH + 2; i++) begin
         w.symbol = CH_OPEN_ANGLE;
         w.line_end = 1'b0;
         send_word(w, 1'b0, '0);
      end
      w.symbol = CH_CLOSE_CURLY;
      w.line_end = 1'b1;
      send_word(w, 1'b0, '0);
      settle();

      program_scores(16'd0, 16'hFFFF, SCORE_W'($urandom), 16'd1, 8'hFF);
      sender_idle_pct = 33;
      reader_idle_pct = 79;
      run_lines(420);
      settle();

      program_scores(SCORE_W'($urandom), SCORE_W'($urandom), SCORE_W'($urandom),
                     SCORE_W'($urandom), CSR_IDX_W'($urandom_range(255, NUM_SCORES)));
      sender_idle_pct = 79;
      reader_idle_pct = 33;
      run_lines(420);
      settle();

      program_scores(SCORE_W'($urandom), 16'd0, 16'hFFFF, SCORE_W'($urandom),
                     CSR_IDX_W'($urandom_range(255, NUM_SCORES)));
      sender_idle_pct = 0;
      reader_idle_pct = 0;
      hold_toggle <= ~hold_toggle;
      run_lines(420);
      settle();

      // top penalty on every closer kind
      program_scores(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd4);
      run_lines(20);
      settle();
      repeat (8) @(posedge clock);

      if (mismatch_count == 0 && expected_lines.size() == 0)
         $display("bracket_match_checker_unit_tb OK");
      else
         $display("bracket_match_checker_unit_tb NOT OK");
      $finish;
   end

endmodule
